/* rtl/core/btinterp_pkg.sv */
package btinterp_pkg;

  // Default sizes of the held map.
  localparam int DEF_MAX_ROWS    = 16;
  localparam int DEF_MAX_COLS    = 16;
  localparam int DEF_VALUE_WIDTH = 16;

  // Fixed field widths of the stream and configuration ports.
  localparam int FIELD_W     = 16;
  localparam int IDX_W       = 8;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 16;
  localparam int CNT_W       = 5;

  // Request codes carried on in_tuser.
  localparam logic [1:0] REQ_WR_ROW  = 2'd0;
  localparam logic [1:0] REQ_WR_COL  = 2'd1;
  localparam logic [1:0] REQ_WR_CELL = 2'd2;
  localparam logic [1:0] REQ_LOOKUP  = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_ROW_COUNT = 1'b0;
  localparam logic CFG_COL_COUNT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_TABLE  = 2'd1,
    ST_ZERO_STEP = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  // Item class decided by the front end.
  typedef enum logic [2:0] {
    K_WR_ROW  = 3'd0,
    K_WR_COL  = 3'd1,
    K_WR_CELL = 3'd2,
    K_LOOKUP  = 3'd3,
    K_BAD     = 3'd4
  } kind_t;

  // Queue entry between the front and back ends.
  typedef struct packed {
    kind_t              kind;
    logic [IDX_W-1:0]   idx;
    logic [FIELD_W-1:0] data;
    logic [FIELD_W-1:0] row_pt;
    logic [FIELD_W-1:0] col_pt;
  } item_t;

endpackage

/* rtl/core/btinterp_ram.sv */
module btinterp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

/* rtl/core/btinterp_front.sv */
module btinterp_front import btinterp_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic [1:0]            in_tuser,
  output logic                  q_valid,
  input  logic                  q_ready,
  output item_t                 q_item
);

  item_t      item_c;
  item_t      fifo_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       push;
  logic       pop;

  // Unpack the transfer and classify it, range checks included.
  always_comb begin
    item_c.idx    = in_tdata[7:0];
    item_c.data   = in_tdata[23:8];
    item_c.row_pt = in_tdata[39:24];
    item_c.col_pt = in_tdata[55:40];
    unique case (in_tuser)
      REQ_WR_ROW:  item_c.kind = (int'(item_c.idx) < MAX_ROWS) ? K_WR_ROW : K_BAD;
      REQ_WR_COL:  item_c.kind = (int'(item_c.idx) < MAX_COLS) ? K_WR_COL : K_BAD;
      REQ_WR_CELL: item_c.kind = (int'(item_c.idx) < MAX_ROWS * MAX_COLS) ? K_WR_CELL : K_BAD;
      REQ_LOOKUP:  item_c.kind = K_LOOKUP;
      default:     item_c.kind = K_BAD;
    endcase
  end

  assign in_tready = (cnt_r != 2'd2);
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = fifo_r[rp_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  // Two-entry queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wp_r] <= item_c;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

/* rtl/core/btinterp_div.sv */
module btinterp_div #(
  parameter int NW   = 56,
  parameter int DENW = 36,
  parameter int DW   = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic signed [NW-1:0]   num,
  input  logic signed [DENW-1:0] den,
  output logic                   done,
  output logic signed [DW-1:0]   quo
);

  localparam int CTW = $clog2(NW + 1);
  localparam logic signed [NW:0] QMAX = (NW+1)'(2**(DW-1) - 1);
  localparam logic signed [NW:0] QMIN = (NW+1)'(-(2**(DW-1)));

  logic            busy_r;
  logic [CTW-1:0]  cnt_r;
  logic [DENW-1:0] rem_r;
  logic [DENW-1:0] ud_r;
  logic [NW-1:0]   dq_r;
  logic            neg_r;
  logic            done_r;
  logic signed [DW-1:0] quo_r;

  logic [DENW:0]      sh;
  logic               ge;
  logic [DENW:0]      diff;
  logic signed [NW:0] qs;

  // One quotient bit per cycle, restoring form on magnitudes.
  assign sh   = {rem_r, dq_r[NW-1]};
  assign ge   = (sh >= {1'b0, ud_r});
  assign diff = sh - {1'b0, ud_r};
  assign qs   = neg_r ? -$signed({1'b0, dq_r}) : $signed({1'b0, dq_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CTW'(NW)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[NW-1] ^ den[DENW-1];
      dq_r  <= num[NW-1] ? NW'(-num) : NW'(num);
      ud_r  <= den[DENW-1] ? DENW'(-den) : DENW'(den);
      rem_r <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      if (cnt_r != CTW'(NW)) begin
        rem_r <= ge ? DENW'(diff) : DENW'(sh);
        dq_r  <= {dq_r[NW-2:0], ge};
        cnt_r <= cnt_r + CTW'(1);
      end else begin
        // Apply the sign and clamp to the value range.
        if (qs > QMAX) begin
          quo_r <= DW'(QMAX);
        end else if (qs < QMIN) begin
          quo_r <= DW'(QMIN);
        end else begin
          quo_r <= DW'(qs);
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

/* rtl/core/btinterp_back.sv */
module btinterp_back import btinterp_pkg::*; #(
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int MAX_COLS    = DEF_MAX_COLS,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  input  logic                   cfg_index,
  input  logic [CNT_W-1:0]       cfg_data,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  item_t                  q_item,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [1:0]             out_tuser
);

  localparam int DW    = (VALUE_WIDTH < FIELD_W) ? VALUE_WIDTH : FIELD_W;
  localparam int OW    = DW + 2;
  localparam int P1W   = 2 * OW;
  localparam int P2W   = 3 * OW;
  localparam int NW    = 3 * OW + 2;
  localparam int DENW  = 2 * OW;
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int CAW   = $clog2(CELLS);
  localparam int MAXN  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int NCW   = $clog2(MAXN + 1);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_SRCH = 10'b0000000010,
    S_HDR1 = 10'b0000000100,
    S_HDR2 = 10'b0000001000,
    S_CELL = 10'b0000010000,
    S_CHK  = 10'b0000100000,
    S_MULA = 10'b0001000000,
    S_MULB = 10'b0010000000,
    S_DIV  = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_t;

  typedef enum logic [1:0] {M_SINGLE, M_ROW, M_COL, M_BI} mode_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] row_count_r;
  logic [CNT_W-1:0] col_count_r;

  logic signed [DW-1:0] row_axis_r [MAX_ROWS];
  logic signed [DW-1:0] col_axis_r [MAX_COLS];

  logic signed [DW-1:0] p_r, q_r;
  logic [NCW-1:0]       i_r;
  logic [RW-1:0]        r1_r, r2_r;
  logic [CW-1:0]        k1_r, k2_r;
  logic signed [DW-1:0] h1_r, h2_r, g1_r, g2_r;
  logic [2:0]           cell_cnt_r;
  logic signed [OW-1:0] c11_r, c12_r, c21_r, c22_r;
  logic signed [OW-1:0] dr_r, dc_r, dp_lo_r, dp_hi_r, dq_lo_r, dq_hi_r, dcr_r, dcc_r;
  mode_t                mode_r;
  logic [2:0]           t_r;
  logic signed [P1W-1:0] p1_r;
  logic signed [NW-1:0]  acc_r;
  logic signed [DW-1:0]  res_val_r;
  status_t               res_st_r;
  logic                  out_valid_r;
  logic [OUT_TDATA_W-1:0] out_value_r;
  status_t               out_status_r;

  logic [NCW-1:0]       nr, nc, nmax;
  logic                 srch_done;
  logic [RW-1:0]        r2_c;
  logic [CW-1:0]        k2_c;
  logic signed [DW-1:0] wdata;
  logic                 ram_we, ram_re;
  logic [CAW-1:0]       ram_raddr;
  logic [DW-1:0]        ram_rdata;
  logic [RW-1:0]        ra;
  logic [CW-1:0]        ka;
  mode_t                mode_c;
  logic                 zero_err;
  logic signed [OW-1:0] x_c, y_c, z_c;
  logic [2:0]           nterm;
  logic                 is_den;
  logic signed [P1W-1:0] p1_c;
  logic signed [P2W-1:0] p2_c;
  logic                  div_start, div_done;
  logic signed [DW-1:0]  div_quo;
  logic                  out_free;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= '0;
      col_count_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ROW_COUNT: row_count_r <= cfg_data;
        CFG_COL_COUNT: col_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Counts in use, clamped to the table size.
  assign nr   = NCW'((int'(row_count_r) > MAX_ROWS) ? MAX_ROWS : int'(row_count_r));
  assign nc   = NCW'((int'(col_count_r) > MAX_COLS) ? MAX_COLS : int'(col_count_r));
  assign nmax = (nr > nc) ? nr : nc;

  assign srch_done = (i_r == nmax);
  assign r2_c = ((NCW'(r1_r) + NCW'(1)) < nr) ? r1_r + RW'(1) : r1_r;
  assign k2_c = ((NCW'(k1_r) + NCW'(1)) < nc) ? k1_r + CW'(1) : k1_r;
  assign wdata = q_item.data[DW-1:0];

  assign q_ready  = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_tready;

  // Cell store: written from the queue, read four corners in turn.
  assign ram_we    = (state_r == S_IDLE) && q_valid && (q_item.kind == K_WR_CELL);
  assign ram_re    = (state_r == S_CELL) && !cell_cnt_r[2];
  assign ra        = cell_cnt_r[1] ? r2_r : r1_r;
  assign ka        = cell_cnt_r[0] ? k2_r : k1_r;
  assign ram_raddr = CAW'(ra) * CAW'(MAX_COLS) + CAW'(ka);

  btinterp_ram #(
    .WIDTH (DW),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (CAW'(q_item.idx)),
    .wdata (wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Interpolation kind and step check.
  always_comb begin
    if (r1_r == r2_r && k1_r == k2_r) begin
      mode_c = M_SINGLE;
    end else if (r1_r == r2_r) begin
      mode_c = M_ROW;
    end else if (k1_r == k2_r) begin
      mode_c = M_COL;
    end else begin
      mode_c = M_BI;
    end
    zero_err = ((mode_c == M_ROW || mode_c == M_BI) && g1_r == g2_r) ||
               ((mode_c == M_COL || mode_c == M_BI) && h1_r == h2_r);
  end

  // Product terms; the term after the last numerator term is the divisor.
  always_comb begin
    x_c   = OW'(1);
    y_c   = OW'(1);
    z_c   = OW'(1);
    nterm = 3'd1;
    case (mode_r)
      M_SINGLE: begin
        nterm = 3'd1;
        if (t_r == 3'd0) begin
          x_c = c11_r;
        end
      end
      M_ROW: begin
        nterm = 3'd2;
        case (t_r)
          3'd0: begin x_c = c11_r; y_c = dc_r; end
          3'd1: begin x_c = dcr_r; y_c = dq_lo_r; end
          default: x_c = dc_r;
        endcase
      end
      M_COL: begin
        nterm = 3'd2;
        case (t_r)
          3'd0: begin x_c = c11_r; y_c = dr_r; end
          3'd1: begin x_c = dcc_r; y_c = dp_lo_r; end
          default: x_c = dr_r;
        endcase
      end
      default: begin
        nterm = 3'd4;
        case (t_r)
          3'd0: begin x_c = c11_r; y_c = dp_hi_r; z_c = dq_hi_r; end
          3'd1: begin x_c = c12_r; y_c = dp_hi_r; z_c = dq_lo_r; end
          3'd2: begin x_c = c21_r; y_c = dp_lo_r; z_c = dq_hi_r; end
          3'd3: begin x_c = c22_r; y_c = dp_lo_r; z_c = dq_lo_r; end
          default: begin x_c = dr_r; y_c = dc_r; end
        endcase
      end
    endcase
  end

  assign is_den    = (t_r == nterm);
  assign p1_c      = x_c * y_c;
  assign p2_c      = p1_r * z_c;
  assign div_start = (state_r == S_MULB) && is_den;

  btinterp_div #(
    .NW   (NW),
    .DENW (DENW),
    .DW   (DW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (acc_r),
    .den   (DENW'(p2_c)),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          if (q_item.kind == K_LOOKUP && nr != '0 && nc != '0) begin
            state_nxt = S_SRCH;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_SRCH: if (srch_done) state_nxt = S_HDR1;
      S_HDR1: state_nxt = S_HDR2;
      S_HDR2: state_nxt = S_CELL;
      S_CELL: if (cell_cnt_r == 3'd4) state_nxt = S_CHK;
      S_CHK:  state_nxt = zero_err ? S_OUT : S_MULA;
      S_MULA: state_nxt = S_MULB;
      S_MULB: state_nxt = is_den ? S_DIV : S_MULA;
      S_DIV:  if (div_done) state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          res_val_r <= '0;
          res_st_r  <= ST_OK;
          case (q_item.kind)
            K_WR_ROW: row_axis_r[RW'(q_item.idx)] <= wdata;
            K_WR_COL: col_axis_r[CW'(q_item.idx)] <= wdata;
            K_BAD:    res_st_r <= ST_RANGE;
            K_LOOKUP: begin
              res_st_r <= ST_NO_TABLE;
              p_r      <= q_item.row_pt[DW-1:0];
              q_r      <= q_item.col_pt[DW-1:0];
              i_r      <= '0;
              r1_r     <= '0;
              k1_r     <= '0;
            end
            default: ;
          endcase
        end
      end
      S_SRCH: begin
        // Last header not above the point, both axes in step.
        if (!srch_done) begin
          i_r <= i_r + NCW'(1);
          if (i_r < nr && row_axis_r[RW'(i_r)] <= p_r) begin
            r1_r <= RW'(i_r);
          end
          if (i_r < nc && col_axis_r[CW'(i_r)] <= q_r) begin
            k1_r <= CW'(i_r);
          end
        end
      end
      S_HDR1: begin
        h1_r <= row_axis_r[r1_r];
        g1_r <= col_axis_r[k1_r];
        r2_r <= r2_c;
        k2_r <= k2_c;
      end
      S_HDR2: begin
        h2_r       <= row_axis_r[r2_r];
        g2_r       <= col_axis_r[k2_r];
        cell_cnt_r <= '0;
      end
      S_CELL: begin
        cell_cnt_r <= cell_cnt_r + 3'd1;
        case (cell_cnt_r)
          3'd1: c11_r <= OW'($signed(ram_rdata));
          3'd2: c12_r <= OW'($signed(ram_rdata));
          3'd3: c21_r <= OW'($signed(ram_rdata));
          3'd4: c22_r <= OW'($signed(ram_rdata));
          default: ;
        endcase
      end
      S_CHK: begin
        res_val_r <= '0;
        if (zero_err) begin
          res_st_r <= ST_ZERO_STEP;
        end else begin
          res_st_r <= ST_OK;
        end
        mode_r  <= mode_c;
        t_r     <= '0;
        acc_r   <= '0;
        dr_r    <= OW'(h2_r) - OW'(h1_r);
        dc_r    <= OW'(g2_r) - OW'(g1_r);
        dp_lo_r <= OW'(p_r) - OW'(h1_r);
        dp_hi_r <= OW'(h2_r) - OW'(p_r);
        dq_lo_r <= OW'(q_r) - OW'(g1_r);
        dq_hi_r <= OW'(g2_r) - OW'(q_r);
        dcr_r   <= c12_r - c11_r;
        dcc_r   <= c21_r - c11_r;
      end
      S_MULA: p1_r <= p1_c;
      S_MULB: begin
        if (!is_den) begin
          acc_r <= acc_r + NW'(p2_c);
          t_r   <= t_r + 3'd1;
        end
      end
      S_DIV: begin
        if (div_done) begin
          res_val_r <= div_quo;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_value_r  <= OUT_TDATA_W'(res_val_r);
          out_status_r <= res_st_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;

endmodule

/* rtl/core/bilinear_table_interpolator.sv */
// Bilinear map lookup with one held table. Items enter a two-entry queue and
// are carried out one at a time. A header or cell write passes from the queue
// through the output state into the output register. A lookup runs a bracket
// search over the first max(row_count, col_count) headers (counts clamped to
// the table size), then header and cell reads, a step check, the product terms
// (2 for a single cell, 3 terms for one axis, 5 for both), the bit-serial
// divider on values of VALUE_WIDTH capped at 16 bits, and the output register.
// Cell and header stores hold no reset value; read only written entries.
module bilinear_table_interpolator import btinterp_pkg::*; #(
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int MAX_COLS    = DEF_MAX_COLS,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // entry_index[7:0], write_data[23:8], row_point[39:24], col_point[55:40]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // req_type[1:0]
  input  logic [1:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // value[15:0]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // status[1:0]
  output logic [1:0]             out_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [CNT_W-1:0]       cfg_data
);

  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  btinterp_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  btinterp_back #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Any result with an error status carries a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata == '0)
    else $error("nonzero value with error status");

  // A queued item waiting for the back end stays put.
  a_queue_hold: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && !q_ready |=> q_valid && $stable(q_item))
    else $error("queue head changed while stalled");

  // The front stalls the input only while an item waits in the queue.
  a_queue_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> q_valid)
    else $error("input stalled with empty queue");

endmodule
